>>> rtl/core/mawp_pkg.sv
// shared types, constants and helpers of the minimum accumulated weight picker
`timescale 1ns / 1ps
`default_nettype none
package mawp_pkg;

    localparam int NUM_BACKENDS = 8;
    localparam int ACC_WIDTH    = 48;
    localparam int SLOTS        = 8;
    localparam int SLOT_W       = 3;
    localparam int CNT_W        = 48;
    localparam int OUT_W        = 48;
    localparam int STEP_W       = 16;
    localparam int CMD_W        = 2;
    localparam int UNIT_W       = (ACC_WIDTH > CNT_W) ? ACC_WIDTH : CNT_W;

    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TUSER_W  = 1;
    localparam int OUT_FIELDS_W = SLOT_W + 3 * OUT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int ACC_LSB  = SLOT_W;
    localparam int SUCC_LSB = ACC_LSB + OUT_W;
    localparam int FAIL_LSB = SUCC_LSB + OUT_W;

    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};
    localparam logic [CNT_W-1:0]     CNT_MAX = {CNT_W{1'b1}};
    localparam logic [STEP_W-1:0]    STEP_RESET = STEP_W'(256);

    typedef enum logic [CMD_W-1:0] {
        CMD_PICK    = 2'd0,
        CMD_SUCCESS = 2'd1,
        CMD_FAILURE = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic {
        OP_LT,
        OP_ADD
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD,
        ST_REPORT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              idle;
        logic              scan;
        logic              scan_first;
        logic              add;
        logic              report;
        logic              emit;
        logic [SLOT_W-1:0] idx;
    } t_ctrl;

    function automatic logic [OUT_W-1:0] acc_out(input logic [ACC_WIDTH-1:0] a);
        logic [UNIT_W-1:0] t;
        t = UNIT_W'(a);
        return t[OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/mawp_alu.sv
// shared compare and saturating add unit
`timescale 1ns / 1ps
`default_nettype none
module mawp_alu (
    input  wire mawp_pkg::t_op              i_op,
    input  wire [mawp_pkg::UNIT_W-1:0]      i_a,
    input  wire [mawp_pkg::UNIT_W-1:0]      i_b,
    input  wire [mawp_pkg::UNIT_W-1:0]      i_limit,
    output logic                            o_lt,
    output logic [mawp_pkg::UNIT_W-1:0]     o_res,
    output logic                            o_sat
);

    logic [mawp_pkg::UNIT_W:0] sum;

    always_comb begin
        sum   = {1'b0, i_a} + {1'b0, i_b};
        o_lt  = 1'b0;
        o_res = '0;
        o_sat = 1'b0;
        case (i_op)
            mawp_pkg::OP_LT: begin
                o_lt = (i_a < i_b);
            end
            mawp_pkg::OP_ADD: begin
                o_res = (sum > {1'b0, i_limit}) ? i_limit : sum[mawp_pkg::UNIT_W-1:0];
                o_sat = (o_res == i_limit);
            end
            default: begin
                o_lt = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/mawp_ctrl.sv
// sequencer: scan index and command state machine
`timescale 1ns / 1ps
`default_nettype none
module mawp_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_accept,
    input  wire mawp_pkg::t_cmd   i_cmd,
    input  wire                   i_out_free,
    output mawp_pkg::t_ctrl       o_ctrl
);

    mawp_pkg::t_state r_state, n_state;
    logic [mawp_pkg::SLOT_W-1:0] r_idx, n_idx;
    logic scan_last;

    assign scan_last = (r_idx == mawp_pkg::SLOT_W'(mawp_pkg::NUM_BACKENDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mawp_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            mawp_pkg::ST_IDLE: begin
                n_idx = '0;
                if (i_in_accept) begin
                    case (i_cmd)
                        mawp_pkg::CMD_PICK:    n_state = mawp_pkg::ST_SCAN;
                        mawp_pkg::CMD_SUCCESS: n_state = mawp_pkg::ST_REPORT;
                        mawp_pkg::CMD_FAILURE: n_state = mawp_pkg::ST_REPORT;
                        default:               n_state = mawp_pkg::ST_EMIT;
                    endcase
                end
            end
            mawp_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = mawp_pkg::ST_ADD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            mawp_pkg::ST_ADD:    n_state = mawp_pkg::ST_EMIT;
            mawp_pkg::ST_REPORT: n_state = mawp_pkg::ST_EMIT;
            mawp_pkg::ST_EMIT: begin
                if (i_out_free) begin
                    n_state = mawp_pkg::ST_IDLE;
                end
            end
            default: n_state = mawp_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl            = '0;
        o_ctrl.idx        = r_idx;
        case (r_state)
            mawp_pkg::ST_IDLE:   o_ctrl.idle = 1'b1;
            mawp_pkg::ST_SCAN: begin
                o_ctrl.scan       = 1'b1;
                o_ctrl.scan_first = (r_idx == '0);
            end
            mawp_pkg::ST_ADD:    o_ctrl.add = 1'b1;
            mawp_pkg::ST_REPORT: o_ctrl.report = 1'b1;
            mawp_pkg::ST_EMIT:   o_ctrl.emit = i_out_free;
            default:             o_ctrl.idle = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/min_accumulated_weight_picker.sv
// top level: per-backend state, shared unit, sequencer and output register
//
// usage
//  - configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes the
//    weight step of backend i_cfg_index and loads its accumulator with that step;
//    always ready, write only while the block is idle
//  - input stream: s_axis_tuser carries the command (pick, success, failure),
//    s_axis_tdata[2:0] the backend a report refers to
//  - output stream: one item per input item, m_axis_tuser is the saturated flag
//  - a pick scans the accumulators one per cycle through the shared compare unit,
//    then the add state adds the step and the emit state loads the output register
//  - a report passes through the report and emit states, an unused command only
//    through the emit state
//  - s_axis_tready is high only while idle; the block takes no new item until its
//    emit state has loaded the output register
//  - the next item is taken while a finished item still waits in the output register;
//    if the receiver stalls the new item waits in its result register until the
//    output register frees
//  - synchronous active-low reset: steps to 1.0, accumulators and counters to zero
`timescale 1ns / 1ps
`default_nettype none
module min_accumulated_weight_picker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [mawp_pkg::SLOT_W-1:0]           i_cfg_index,
    input  wire [mawp_pkg::STEP_W-1:0]           i_cfg_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [2:0] report_backend, rest zero
    input  wire [mawp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [1:0] cmd
    input  wire [mawp_pkg::CMD_W-1:0]            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // [2:0] chosen_backend, [50:3] accumulated_weight, [98:51] success_count,
    // [146:99] failure_count, rest zero
    output logic [mawp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] saturated
    output logic [mawp_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    localparam int SW = mawp_pkg::SLOT_W;
    localparam int AW = mawp_pkg::ACC_WIDTH;
    localparam int CW = mawp_pkg::CNT_W;
    localparam int OW = mawp_pkg::OUT_W;
    localparam int UW = mawp_pkg::UNIT_W;

    mawp_pkg::t_ctrl ctrl;
    logic in_accept, out_accept, out_free, cfg_write;

    logic [mawp_pkg::STEP_W-1:0] r_step [mawp_pkg::SLOTS];
    logic [AW-1:0]               r_acc  [mawp_pkg::SLOTS];
    logic [CW-1:0]               r_succ [mawp_pkg::SLOTS];
    logic [CW-1:0]               r_fail [mawp_pkg::SLOTS];

    mawp_pkg::t_cmd r_cmd;
    logic [SW-1:0]  r_sel;
    logic [AW-1:0]  r_min;

    logic [SW-1:0]  r_res_chosen;
    logic [OW-1:0]  r_res_acc, r_res_succ, r_res_fail;
    logic           r_res_sat;

    logic           r_out_valid;
    logic [SW-1:0]  r_out_chosen;
    logic [OW-1:0]  r_out_acc, r_out_succ, r_out_fail;
    logic           r_out_sat;

    logic [SW-1:0]  acc_addr;
    logic [AW-1:0]  acc_rd;
    logic [CW-1:0]  succ_rd, fail_rd, cnt_rd;
    logic           rb_bad;

    mawp_pkg::t_op  u_op;
    logic [UW-1:0]  u_a, u_b, u_limit, u_res;
    logic           u_lt, u_sat;

    assign o_cfg_ready   = 1'b1;
    assign cfg_write     = i_cfg_valid;
    assign s_axis_tready = ctrl.idle;
    assign in_accept     = s_axis_tvalid & ctrl.idle;
    assign out_accept    = r_out_valid & m_axis_tready;
    assign out_free      = ~r_out_valid | m_axis_tready;

    assign acc_addr = ctrl.scan ? ctrl.idx : r_sel;
    assign acc_rd   = r_acc[acc_addr];
    assign succ_rd  = r_succ[r_sel];
    assign fail_rd  = r_fail[r_sel];
    assign cnt_rd   = (r_cmd == mawp_pkg::CMD_SUCCESS) ? succ_rd : fail_rd;
    assign rb_bad   = (int'(r_sel) >= mawp_pkg::NUM_BACKENDS);

    mawp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_cmd       (mawp_pkg::t_cmd'(s_axis_tuser)),
        .i_out_free  (out_free),
        .o_ctrl      (ctrl)
    );

    // operand selection for the shared unit
    always_comb begin
        u_op    = mawp_pkg::OP_LT;
        u_a     = UW'(acc_rd);
        u_b     = UW'(r_min);
        u_limit = UW'(mawp_pkg::ACC_MAX);
        if (ctrl.add) begin
            u_op = mawp_pkg::OP_ADD;
            u_a  = UW'(r_min);
            u_b  = UW'(r_step[r_sel]);
        end else if (ctrl.report) begin
            u_op    = mawp_pkg::OP_ADD;
            u_a     = UW'(cnt_rd);
            u_b     = UW'(1'b1);
            u_limit = UW'(mawp_pkg::CNT_MAX);
        end
    end

    mawp_alu u_alu (
        .i_op    (u_op),
        .i_a     (u_a),
        .i_b     (u_b),
        .i_limit (u_limit),
        .o_lt    (u_lt),
        .o_res   (u_res),
        .o_sat   (u_sat)
    );

    // per-backend state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mawp_pkg::SLOTS; i++) begin
                r_step[i] <= mawp_pkg::STEP_RESET;
                r_acc[i]  <= '0;
                r_succ[i] <= '0;
                r_fail[i] <= '0;
            end
        end else begin
            if (cfg_write) begin
                r_step[i_cfg_index] <= i_cfg_data;
                r_acc[i_cfg_index]  <= {{(AW - mawp_pkg::STEP_W){1'b0}}, i_cfg_data};
            end else if (ctrl.add) begin
                r_acc[r_sel] <= u_res[AW-1:0];
            end
            if (ctrl.report && !rb_bad) begin
                if (r_cmd == mawp_pkg::CMD_SUCCESS) begin
                    r_succ[r_sel] <= u_res[CW-1:0];
                end else begin
                    r_fail[r_sel] <= u_res[CW-1:0];
                end
            end
        end
    end

    // item registers and result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd        <= mawp_pkg::t_cmd'(s_axis_tuser);
            r_sel        <= (mawp_pkg::t_cmd'(s_axis_tuser) == mawp_pkg::CMD_PICK) ?
                            '0 : s_axis_tdata[SW-1:0];
            r_res_chosen <= '0;
            r_res_acc    <= '0;
            r_res_succ   <= '0;
            r_res_fail   <= '0;
            r_res_sat    <= 1'b0;
        end else if (ctrl.scan) begin
            if (ctrl.scan_first || u_lt) begin
                r_min <= acc_rd;
                r_sel <= ctrl.idx;
            end
        end else if (ctrl.add) begin
            r_res_chosen <= r_sel;
            r_res_acc    <= mawp_pkg::acc_out(u_res[AW-1:0]);
            r_res_succ   <= OW'(succ_rd);
            r_res_fail   <= OW'(fail_rd);
            r_res_sat    <= u_sat;
        end else if (ctrl.report) begin
            r_res_chosen <= r_sel;
            if (!rb_bad) begin
                r_res_acc  <= mawp_pkg::acc_out(acc_rd);
                r_res_succ <= (r_cmd == mawp_pkg::CMD_SUCCESS) ? OW'(u_res[CW-1:0])
                                                                : OW'(succ_rd);
                r_res_fail <= (r_cmd == mawp_pkg::CMD_SUCCESS) ? OW'(fail_rd)
                                                                : OW'(u_res[CW-1:0]);
                r_res_sat  <= u_sat;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_out_chosen <= r_res_chosen;
            r_out_acc    <= r_res_acc;
            r_out_succ   <= r_res_succ;
            r_out_fail   <= r_res_fail;
            r_out_sat    <= r_res_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_sat;
    assign m_axis_tdata  = mawp_pkg::OUT_TDATA_W'({r_out_fail, r_out_succ, r_out_acc,
                                                   r_out_chosen});

endmodule
`default_nettype wire

>>> rtl/core/mawp_checker.sv
// port-level checks of the picker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mawp_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  s_axis_tvalid,
    input wire                                  s_axis_tready,
    input wire                                  m_axis_tvalid,
    input wire                                  m_axis_tready,
    input wire [mawp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input wire [mawp_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

    localparam int AL = mawp_pkg::ACC_LSB;
    localparam int SL = mawp_pkg::SUCC_LSB;
    localparam int FL = mawp_pkg::FAIL_LSB;
    localparam int OW = mawp_pkg::OUT_W;

    // a stalled item stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(m_axis_tvalid && !m_axis_tready) |-> m_axis_tvalid)
        else $error("output item dropped while stalled");

    // a stalled item keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(m_axis_tvalid && !m_axis_tready)
        |-> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

    // the block works on one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // saturated only when the updated value is at its maximum
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0]
        |-> (mawp_pkg::ACC_WIDTH < OW) || (&m_axis_tdata[AL+OW-1:AL])
            || (&m_axis_tdata[SL+OW-1:SL]) || (&m_axis_tdata[FL+OW-1:FL]))
        else $error("saturated flag without a saturated value");

endmodule

bind min_accumulated_weight_picker mawp_checker u_mawp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
